/* design/irc_ltk_pkg.sv */
// ----------------------------------------------------------------------------
// irc_ltk_pkg
// Shared constants and types for the IRC line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irc_ltk_pkg;

	localparam int unsigned MAX_PARAMS_DEF = 15;
	localparam int unsigned FIFO_DEPTH     = 4;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_MID   = 2'd1,
		KIND_TRAIL = 2'd2,
		KIND_EOL   = 2'd3
	} kind_t;

	// One queued action: an end of line, a held CR to replay, and/or a line byte.
	typedef struct packed {
		logic       lf;
		logic       cr_flush;
		logic       byte_en;
		logic [7:0] data;
	} entry_t;

endpackage

`default_nettype wire

/* design/irc_ltk_front.sv */
// ----------------------------------------------------------------------------
// irc_ltk_front
// Accepts input bytes, resolves held-back CRs and queues line actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irc_ltk_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           in_byte,
	input  wire                  q_full,
	output logic                 q_push,
	output irc_ltk_pkg::entry_t  q_entry
);

	logic cr_pending_q;
	logic is_lf;
	logic is_cr;
	logic accept;

	assign is_lf    = (in_byte == irc_ltk_pkg::CH_LF);
	assign is_cr    = (in_byte == irc_ltk_pkg::CH_CR);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		q_entry.lf       = is_lf;
		q_entry.cr_flush = cr_pending_q && !is_lf;
		q_entry.byte_en  = !is_lf && !is_cr;
		q_entry.data     = in_byte;
	end

	// A lone CR only arms the pending flag and queues nothing.
	assign q_push = accept && (q_entry.lf || q_entry.cr_flush || q_entry.byte_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_pending_q <= 1'b0;
		end else if (accept) begin
			cr_pending_q <= is_cr;
		end
	end

endmodule

`default_nettype wire

/* design/irc_ltk_fifo.sv */
// ----------------------------------------------------------------------------
// irc_ltk_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irc_ltk_fifo (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire irc_ltk_pkg::entry_t  push_entry,
	output logic                      full,
	input  wire                       pop,
	output logic                      head_valid,
	output irc_ltk_pkg::entry_t       head_entry
);

	localparam int unsigned PtrW = $clog2(irc_ltk_pkg::FIFO_DEPTH);
	localparam int unsigned CntW = PtrW + 1;

	irc_ltk_pkg::entry_t mem_q [irc_ltk_pkg::FIFO_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full       = (count_q == CntW'(irc_ltk_pkg::FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* design/irc_ltk_back.sv */
// ----------------------------------------------------------------------------
// irc_ltk_back
// Token state machine and registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irc_ltk_back #(
	parameter int unsigned MAX_PARAMS = irc_ltk_pkg::MAX_PARAMS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       head_valid,
	input  wire irc_ltk_pkg::entry_t  head_entry,
	output logic                      pop,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [7:0]                out_byte,
	output logic [1:0]                out_kind,
	output logic                      out_start,
	output logic [3:0]                out_index,
	output logic                      out_cmd_seen,
	output logic [3:0]                out_total,
	output logic                      out_trail_seen,
	output logic                      out_last
);

	localparam int unsigned CntW = $clog2(MAX_PARAMS + 1);

	typedef enum logic [2:0] {
		POS_SKIP_CMD,
		POS_IN_CMD,
		POS_SKIP_PARAM,
		POS_IN_MIDDLE,
		POS_TRAIL_FIRST,
		POS_IN_TRAIL
	} pos_t;

	pos_t            pos_q;
	logic [CntW-1:0] cnt_q;
	logic [3:0]      idx_q;
	logic            trail_q;
	logic            cmd_q;
	logic            phase_q;

	logic            out_free;
	logic            step;
	logic            two_step;
	logic            cr_phase;
	logic [7:0]      ch;
	logic            ch_sp;
	logic            emit;
	irc_ltk_pkg::kind_t kind;
	logic            start;
	logic            open_p;
	logic            set_trail;
	logic            set_cmd;
	pos_t            npos;
	logic [CntW+3:0] cnt_ext;
	logic [3:0]      cnt_sat;
	logic [3:0]      idx_use;
	logic            step_last;

	assign out_free = !out_valid || out_ready;
	assign step     = head_valid && out_free;
	assign two_step = head_entry.cr_flush && head_entry.byte_en;
	assign cr_phase = head_entry.cr_flush && !phase_q;
	assign pop      = step && !(two_step && !phase_q);
	assign ch       = cr_phase ? irc_ltk_pkg::CH_CR : head_entry.data;
	assign ch_sp    = (ch == irc_ltk_pkg::CH_SP);

	assign cnt_ext  = {4'b0000, cnt_q};
	assign cnt_sat  = (cnt_ext > (CntW + 4)'(15)) ? 4'd15 : cnt_ext[3:0];
	assign idx_use  = open_p ? cnt_sat : idx_q;

	// Handling of one ordinary line byte in the current position.
	always_comb begin
		emit      = 1'b0;
		kind      = irc_ltk_pkg::KIND_CMD;
		start     = 1'b0;
		open_p    = 1'b0;
		set_trail = 1'b0;
		set_cmd   = 1'b0;
		npos      = pos_q;
		unique case (pos_q)
			POS_SKIP_CMD: begin
				if (!ch_sp) begin
					emit    = 1'b1;
					start   = 1'b1;
					set_cmd = 1'b1;
					npos    = POS_IN_CMD;
				end
			end
			POS_IN_CMD: begin
				if (ch_sp) begin
					npos = POS_SKIP_PARAM;
				end else begin
					emit = 1'b1;
				end
			end
			POS_SKIP_PARAM: begin
				if (!ch_sp) begin
					open_p = 1'b1;
					if (ch == irc_ltk_pkg::CH_COLON) begin
						set_trail = 1'b1;
						npos      = POS_TRAIL_FIRST;
					end else begin
						emit  = 1'b1;
						start = 1'b1;
						kind  = irc_ltk_pkg::KIND_MID;
						npos  = POS_IN_MIDDLE;
					end
				end
			end
			POS_IN_MIDDLE: begin
				kind = irc_ltk_pkg::KIND_MID;
				if (ch_sp) begin
					npos = POS_SKIP_PARAM;
				end else begin
					emit = 1'b1;
				end
			end
			POS_TRAIL_FIRST: begin
				emit  = 1'b1;
				start = 1'b1;
				kind  = irc_ltk_pkg::KIND_TRAIL;
				npos  = POS_IN_TRAIL;
			end
			default: begin
				emit = 1'b1;
				kind = irc_ltk_pkg::KIND_TRAIL;
				npos = POS_IN_TRAIL;
			end
		endcase
	end

	// A replayed CR always yields a result; it is the last one unless the
	// following byte yields one too, which only a space inside a command or
	// middle parameter does not.
	always_comb begin
		if (two_step && !phase_q) begin
			step_last = (head_entry.data == irc_ltk_pkg::CH_SP) && (npos != POS_IN_TRAIL);
		end else begin
			step_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_SKIP_CMD;
			cnt_q     <= '0;
			idx_q     <= '0;
			trail_q   <= 1'b0;
			cmd_q     <= 1'b0;
			phase_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid <= 1'b0;
			end
			if (step) begin
				phase_q <= two_step && !phase_q;
				if (head_entry.lf) begin
					out_valid <= 1'b1;
					pos_q     <= POS_SKIP_CMD;
					cnt_q     <= '0;
					idx_q     <= '0;
					trail_q   <= 1'b0;
					cmd_q     <= 1'b0;
				end else begin
					out_valid <= emit;
					pos_q     <= npos;
					idx_q     <= idx_use;
					if (open_p && (cnt_ext < (CntW + 4)'(MAX_PARAMS))) begin
						cnt_q <= cnt_q + CntW'(1);
					end
					if (set_trail) begin
						trail_q <= 1'b1;
					end
					if (set_cmd) begin
						cmd_q <= 1'b1;
					end
				end
			end
		end
	end

	// Result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (step) begin
			if (head_entry.lf) begin
				out_byte       <= 8'h00;
				out_kind       <= irc_ltk_pkg::KIND_EOL;
				out_start      <= 1'b0;
				out_index      <= 4'd0;
				out_cmd_seen   <= cmd_q;
				out_total      <= cnt_sat;
				out_trail_seen <= trail_q;
				out_last       <= 1'b1;
			end else begin
				out_byte       <= ch;
				out_kind       <= kind;
				out_start      <= start;
				out_index      <= (kind == irc_ltk_pkg::KIND_CMD) ? 4'd0 : idx_use;
				out_cmd_seen   <= 1'b0;
				out_total      <= 4'd0;
				out_trail_seen <= 1'b0;
				out_last       <= step_last;
			end
		end
	end

endmodule

`default_nettype wire

/* design/irc_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Streaming IRC line tokenizer: bytes in, tagged token bytes and line ends out.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one received byte per item in s_axis_tdata. The
// master channel gives one result per item: a token byte tagged with its kind
// (tuser), token start and parameter index, or an end-of-line summary with
// command, parameter count and trailing flags. m_axis_tlast marks the final
// result caused by one input byte.
// With an empty queue and a ready receiver a result passes through the queue
// and then the output register after its byte is accepted. Bytes are taken
// one per cycle while the queue is not full. A held CR that is followed by a
// byte other than CR or LF is replayed as a step of its own in the token state
// machine; the CR item itself queued nothing, so the four-entry queue between
// the byte classifier and the token state machine keeps the input at full rate.
// A CR is held until the next byte arrives; a CR-LF pair gives no CR result.
// Reset clears the held CR, the queue and the line state. When the receiver
// stalls, the output register holds its result and the queue fills; once it
// is full s_axis_tready drops until the receiver takes results again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irc_line_tokenizer #(
	parameter int unsigned MAX_PARAMS = irc_ltk_pkg::MAX_PARAMS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [7:0] out_byte, [8] token_start, [12:9] param_index, [13] command_seen,
	// [17:14] param_total, [18] trailing_seen, [23:19] zero
	output logic [23:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);

	irc_ltk_pkg::entry_t push_entry;
	irc_ltk_pkg::entry_t head_entry;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic head_valid;

	logic [7:0] out_byte;
	logic       out_start;
	logic [3:0] out_index;
	logic       out_cmd_seen;
	logic [3:0] out_total;
	logic       out_trail_seen;

	irc_ltk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	irc_ltk_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	irc_ltk_back #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_entry     (head_entry),
		.pop            (q_pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (out_byte),
		.out_kind       (m_axis_tuser),
		.out_start      (out_start),
		.out_index      (out_index),
		.out_cmd_seen   (out_cmd_seen),
		.out_total      (out_total),
		.out_trail_seen (out_trail_seen),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b00000, out_trail_seen, out_total, out_cmd_seen,
		out_index, out_start, out_byte};

endmodule

`default_nettype wire
